// ----- sv/eht_pkg.sv -----
package eht_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int MAX_GD_DEF  = 10;
  localparam int MAX_SEG_DEF = 1024;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4_a793_5bd1_e995;
  localparam logic [63:0] MIX_SEED  = 64'h0000_0000_00c7_0697;
  // seed mixed with the byte length (8) times the multiplier
  localparam logic [63:0] HASH_INIT = MIX_SEED ^ (MIX_MUL << 3);
  localparam logic [63:0] EMPTY_KEY = '1;
  localparam int          FOLD_SHIFT = 47;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_RSV  = 2'd3;

  // slot write kinds
  localparam logic [1:0] KW_DEL = 2'd0;
  localparam logic [1:0] KW_INS = 2'd1;
  localparam logic [1:0] KW_SPE = 2'd2;
  localparam logic [1:0] KW_SPC = 2'd3;

  typedef struct packed {
    logic       cap;
    logic       st_we;
    logic [1:0] st_code;
    logic       val_ld;
    logic       mix_start;
    logic       mix_src;
    logic       hkey_ld;
    logic       dir_rd;
    logic       dir_asel;
    logic       x_ld;
    logic       seg_ld;
    logic       ld_ld;
    logic       idx_clr;
    logic       idx_inc;
    logic       key_rd;
    logic       val_rd;
    logic       key_wr;
    logic [1:0] kw;
    logic       split_go;
    logic       ldn_wr;
    logic       ldo_wr;
    logic       j_init;
    logic       j_dec;
    logic       dbl_w0;
    logic       dbl_w1;
    logic       gd_inc;
    logic       hj_clr;
    logic       hj_inc;
    logic       hf_wr;
    logic       init_wr;
    logic       ini_inc;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       is_rsv;
    logic       ini_last;
    logic       kq_empty;
    logic       kq_match;
    logic       idx_last;
    logic       mix_done;
    logic       stale;
    logic       split_bit;
    logic       full;
    logic       dbl;
    logic       j_zero;
    logic       hj_last;
    logic       out_busy;
  } stat_t;

  function automatic logic [63:0] fold(input logic [63:0] v);
    return v ^ (v >> FOLD_SHIFT);
  endfunction

endpackage

// ----- sv/extendible_hash_table_top.sv -----
// Extendible hash table of 64-bit keys and values, one request at a time.
// After reset the block clears the slots of its first two segments, with
// in_stall high. A request is hashed by a shared 64-bit mix unit that builds
// each of its four multiplies from three 32x32 partial products. Search and
// delete then look up the directory and the local depth and scan the slots
// of the segment. An insert rehashes every occupied slot it passes. A split
// handles every slot of the old segment, then doubles the directory or
// redirects directory entries, before the insert is retried.
module extendible_hash_table_top import eht_pkg::*; #(
  parameter int SLOTS_PER_SEGMENT = SLOTS_DEF,
  parameter int MAX_GLOBAL_DEPTH  = MAX_GD_DEF,
  parameter int MAX_SEGMENTS      = MAX_SEG_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [63:0] key,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] found_value
);

  cmd_t  cmd;
  stat_t stat;

  eht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  eht_dp #(
    .SLOTS   (SLOTS_PER_SEGMENT),
    .MAX_GD  (MAX_GLOBAL_DEPTH),
    .MAX_SEG (MAX_SEGMENTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .action      (action),
    .key         (key),
    .value       (value),
    .cmd         (cmd),
    .stat        (stat),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .status      (status),
    .found_value (found_value)
  );

endmodule

// ----- sv/eht_mix.sv -----
module eht_mix import eht_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] din,
  output logic        done,
  output logic [63:0] dout
);

  logic [63:0] a;
  logic [63:0] acc;
  logic [1:0]  ph;
  logic [1:0]  mi;
  logic        run;
  logic [31:0] op_a;
  logic [31:0] op_m;
  logic [63:0] pp;
  logic [63:0] sum;

  // low 64 bits of a * MIX_MUL from three 32x32 partial products
  always_comb begin
    op_a = (ph == 2'd2) ? a[63:32] : a[31:0];
    op_m = (ph == 2'd1) ? MIX_MUL[63:32] : MIX_MUL[31:0];
    pp   = op_a * op_m;
    sum  = acc + {pp[31:0], 32'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      ph   <= 2'd0;
      mi   <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a   <= din;
        ph  <= 2'd0;
        mi  <= 2'd0;
        run <= 1'b1;
      end else if (run) begin
        unique case (ph)
          2'd0: begin
            acc <= pp;
            ph  <= 2'd1;
          end
          2'd1: begin
            acc <= sum;
            ph  <= 2'd2;
          end
          2'd2: begin
            ph <= 2'd0;
            mi <= mi + 2'd1;
            unique case (mi)
              2'd0: a <= fold(sum);
              2'd1: a <= sum ^ HASH_INIT;
              2'd2: a <= fold(sum);
              2'd3: begin
                dout <= fold(sum);
                run  <= 1'b0;
                done <= 1'b1;
              end
            endcase
          end
          default: ph <= 2'd0;
        endcase
      end
    end
  end

endmodule

// ----- sv/eht_dp.sv -----
module eht_dp import eht_pkg::*; #(
  parameter int SLOTS   = SLOTS_DEF,
  parameter int MAX_GD  = MAX_GD_DEF,
  parameter int MAX_SEG = MAX_SEG_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  action,
  input  logic [63:0] key,
  input  logic [63:0] value,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [1:0]  status,
  output logic [63:0] found_value
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SEG_W  = $clog2(MAX_SEG);
  localparam int NF_W   = SEG_W + 1;
  localparam int DIR_AW = MAX_GD;
  localparam int DIR_N  = 1 << MAX_GD;
  localparam int LD_W   = $clog2(MAX_GD + 1);
  localparam int SLOT_N = MAX_SEG * SLOTS;
  localparam int ADDR_W = $clog2(SLOT_N);
  localparam int INI_W  = $clog2(2 * SLOTS);

  logic [SEG_W-1:0]  dir_mem [DIR_N];
  logic [LD_W-1:0]   ld_mem  [MAX_SEG];
  logic [63:0]       key_mem [SLOT_N];
  logic [63:0]       val_mem [SLOT_N];

  logic [1:0]        act_r;
  logic [63:0]       key_r;
  logic [63:0]       val_r;
  logic [1:0]        res_st;
  logic [63:0]       res_val;
  logic [63:0]       hkey;
  logic [DIR_AW-1:0] x_r;
  logic [SEG_W-1:0]  seg;
  logic [LD_W-1:0]   ldr;
  logic [SLOT_W-1:0] idx;
  logic [SEG_W-1:0]  ns;
  logic [NF_W-1:0]   next_free;
  logic [LD_W-1:0]   gd;
  logic [DIR_AW-1:0] j;
  logic [DIR_AW-1:0] hj;
  logic [INI_W-1:0]  ini;
  logic [SEG_W-1:0]  dir_q;
  logic [LD_W-1:0]   ld_q;
  logic [63:0]       key_q;
  logic [63:0]       val_q;

  logic              mix_done;
  logic [63:0]       mix_out;
  logic [63:0]       mix_din;

  logic [DIR_AW-1:0] h_top;
  logic [DIR_AW-1:0] k_top;
  logic [DIR_AW-1:0] x_c;
  logic [DIR_AW-1:0] diff;
  logic [DIR_AW-1:0] sb_vec;
  logic [LD_W-1:0]   sh;
  logic [DIR_AW-1:0] hf_low;
  logic [DIR_AW-1:0] half;
  logic [DIR_AW-1:0] hf_addr;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] new_addr;
  logic              ini_lo;

  logic              key_we;
  logic [ADDR_W-1:0] key_wa;
  logic [63:0]       key_wd;
  logic              val_we;
  logic [ADDR_W-1:0] val_wa;
  logic [63:0]       val_wd;
  logic              dir_we;
  logic [DIR_AW-1:0] dir_wa;
  logic [SEG_W-1:0]  dir_wd;
  logic [DIR_AW-1:0] dir_ra;

  assign mix_din = cmd.mix_src ? key_q : key_r;

  eht_mix u_mix (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mix_start),
    .din   (mix_din),
    .done  (mix_done),
    .dout  (mix_out)
  );

  always_comb begin
    h_top    = hkey[63 -: MAX_GD];
    k_top    = mix_out[63 -: MAX_GD];
    x_c      = h_top >> (LD_W'(MAX_GD) - gd);
    diff     = (k_top ^ h_top) >> (LD_W'(MAX_GD) - ldr);
    sb_vec   = k_top >> (LD_W'(MAX_GD - 1) - ldr);
    sh       = gd - ldr;
    hf_low   = ~({DIR_AW{1'b1}} << sh);
    half     = DIR_AW'(1) << (sh - LD_W'(1));
    hf_addr  = (x_r & ~hf_low) | half | hj;
    cur_addr = ADDR_W'(seg) * ADDR_W'(SLOTS) + ADDR_W'(idx);
    new_addr = ADDR_W'(ns) * ADDR_W'(SLOTS) + ADDR_W'(idx);
    ini_lo   = (ini >> 1) == '0;
    dir_ra   = cmd.dir_asel ? j : x_c;
  end

  always_comb begin
    stat.act       = act_r;
    stat.is_rsv    = key_r == EMPTY_KEY;
    stat.ini_last  = ini == INI_W'(2 * SLOTS - 1);
    stat.kq_empty  = key_q == EMPTY_KEY;
    stat.kq_match  = key_q == key_r;
    stat.idx_last  = idx == SLOT_W'(SLOTS - 1);
    stat.mix_done  = mix_done;
    stat.stale     = |diff;
    stat.split_bit = sb_vec[0];
    stat.full      = (next_free >= NF_W'(MAX_SEG)) ||
                     ((ldr >= gd) && (gd >= LD_W'(MAX_GD)));
    stat.dbl       = ldr >= gd;
    stat.j_zero    = j == '0;
    stat.hj_last   = hj == half - DIR_AW'(1);
    stat.out_busy  = out_valid && out_stall;
  end

  // slot store write port
  always_comb begin
    key_we = 1'b0;
    key_wa = cur_addr;
    key_wd = EMPTY_KEY;
    val_we = 1'b0;
    val_wa = cur_addr;
    val_wd = val_r;
    if (cmd.init_wr) begin
      key_we = 1'b1;
      key_wa = ADDR_W'(ini);
    end else if (cmd.key_wr) begin
      key_we = 1'b1;
      unique case (cmd.kw)
        KW_DEL: key_wd = EMPTY_KEY;
        KW_INS: begin
          key_wd = key_r;
          val_we = 1'b1;
        end
        KW_SPE: key_wa = new_addr;
        KW_SPC: begin
          key_wa = new_addr;
          key_wd = key_q;
          val_we = 1'b1;
          val_wa = new_addr;
          val_wd = val_q;
        end
      endcase
    end
  end

  // directory write port
  always_comb begin
    dir_we = 1'b0;
    dir_wa = x_r;
    dir_wd = ns;
    priority if (cmd.init_wr && ini_lo) begin
      dir_we = 1'b1;
      dir_wa = DIR_AW'(ini);
      dir_wd = SEG_W'(ini);
    end else if (cmd.dbl_w0) begin
      dir_we = 1'b1;
      dir_wa = j << 1;
      dir_wd = dir_q;
    end else if (cmd.dbl_w1) begin
      dir_we = 1'b1;
      dir_wa = (j << 1) | DIR_AW'(1);
      dir_wd = (j == x_r) ? ns : dir_q;
    end else if (cmd.hf_wr) begin
      dir_we = 1'b1;
      dir_wa = hf_addr;
      dir_wd = ns;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    if (cmd.key_rd) key_q <= key_mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    if (cmd.val_rd) val_q <= val_mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
    if (cmd.dir_rd) dir_q <= dir_mem[dir_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.init_wr && ini_lo) begin
      ld_mem[SEG_W'(ini)] <= LD_W'(1);
    end else if (cmd.ldn_wr) begin
      ld_mem[ns] <= ldr + LD_W'(1);
    end else if (cmd.ldo_wr) begin
      ld_mem[seg] <= ldr + LD_W'(1);
    end
    if (cmd.seg_ld) ld_q <= ld_mem[dir_q];
  end

  // payload, result and lookup registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      act_r <= action;
      key_r <= key;
      val_r <= value;
    end
    if (cmd.cap) begin
      res_st  <= ST_MISS;
      res_val <= '0;
    end else begin
      if (cmd.st_we) res_st <= cmd.st_code;
      if (cmd.val_ld) res_val <= val_q;
    end
    if (cmd.hkey_ld) hkey <= mix_out;
    if (cmd.x_ld) x_r <= x_c;
    if (cmd.seg_ld) seg <= dir_q;
    if (cmd.ld_ld) ldr <= ld_q;
    if (cmd.split_go) ns <= next_free[SEG_W-1:0];
    if (cmd.out_load) begin
      status      <= res_st;
      found_value <= res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free <= NF_W'(2);
      gd        <= LD_W'(1);
      ini       <= '0;
      idx       <= '0;
      j         <= '0;
      hj        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ini_inc) ini <= ini + INI_W'(1);
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + SLOT_W'(1);
      end
      if (cmd.split_go) next_free <= next_free + NF_W'(1);
      if (cmd.gd_inc) gd <= gd + LD_W'(1);
      if (cmd.j_init) begin
        j <= (DIR_AW'(1) << gd) - DIR_AW'(1);
      end else if (cmd.j_dec) begin
        j <= j - DIR_AW'(1);
      end
      if (cmd.hj_clr) begin
        hj <= '0;
      end else if (cmd.hj_inc) begin
        hj <= hj + DIR_AW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/eht_ctrl.sv -----
module eht_ctrl import eht_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [4:0] S_INIT      = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_CHECK     = 5'd2;
  localparam logic [4:0] S_HASH_K    = 5'd3;
  localparam logic [4:0] S_LOOK      = 5'd4;
  localparam logic [4:0] S_LOOK_SEG  = 5'd5;
  localparam logic [4:0] S_LOOK_LD   = 5'd6;
  localparam logic [4:0] S_SCAN_RD   = 5'd7;
  localparam logic [4:0] S_SCAN_CHK  = 5'd8;
  localparam logic [4:0] S_SCAN_HASH = 5'd9;
  localparam logic [4:0] S_INS_WR    = 5'd10;
  localparam logic [4:0] S_VAL_RD    = 5'd11;
  localparam logic [4:0] S_VAL_OUT   = 5'd12;
  localparam logic [4:0] S_SPL_CHK   = 5'd13;
  localparam logic [4:0] S_SP_RD     = 5'd14;
  localparam logic [4:0] S_SP_CHK    = 5'd15;
  localparam logic [4:0] S_SP_HASH   = 5'd16;
  localparam logic [4:0] S_SP_VRD    = 5'd17;
  localparam logic [4:0] S_SP_VWR    = 5'd18;
  localparam logic [4:0] S_SP_LDN    = 5'd19;
  localparam logic [4:0] S_SP_LDO    = 5'd20;
  localparam logic [4:0] S_DB_RD     = 5'd21;
  localparam logic [4:0] S_DB_W0     = 5'd22;
  localparam logic [4:0] S_DB_W1     = 5'd23;
  localparam logic [4:0] S_HF_WR     = 5'd24;
  localparam logic [4:0] S_FIN       = 5'd25;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [4:0] sp_step;

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    // advance the split copy to the next slot or finish it
    sp_step    = stat.idx_last ? S_SP_LDN : S_SP_RD;
    unique case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        cmd.ini_inc = 1'b1;
        if (stat.ini_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat.is_rsv) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ST_RSV;
          state_next  = S_FIN;
        end else if (stat.act == ACT_NONE) begin
          state_next = S_FIN;
        end else begin
          cmd.mix_start = 1'b1;
          state_next    = S_HASH_K;
        end
      end
      S_HASH_K: begin
        if (stat.mix_done) begin
          cmd.hkey_ld = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.dir_rd = 1'b1;
        cmd.x_ld   = 1'b1;
        state_next = S_LOOK_SEG;
      end
      S_LOOK_SEG: begin
        cmd.seg_ld = 1'b1;
        state_next = S_LOOK_LD;
      end
      S_LOOK_LD: begin
        cmd.ld_ld   = 1'b1;
        cmd.idx_clr = 1'b1;
        state_next  = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.key_rd = 1'b1;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        priority if (stat.act == ACT_INSERT) begin
          if (stat.kq_empty) begin
            state_next = S_INS_WR;
          end else begin
            cmd.mix_start = 1'b1;
            cmd.mix_src   = 1'b1;
            state_next    = S_SCAN_HASH;
          end
        end else if (stat.kq_match) begin
          if (stat.act == ACT_SEARCH) begin
            state_next = S_VAL_RD;
          end else begin
            cmd.key_wr  = 1'b1;
            cmd.kw      = KW_DEL;
            cmd.st_we   = 1'b1;
            cmd.st_code = ST_DONE;
            state_next  = S_FIN;
          end
        end else if (stat.idx_last) begin
          state_next = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_SCAN_HASH: begin
        if (stat.mix_done) begin
          priority if (stat.stale) begin
            state_next = S_INS_WR;
          end else if (stat.idx_last) begin
            state_next = S_SPL_CHK;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_SCAN_RD;
          end
        end
      end
      S_INS_WR: begin
        cmd.key_wr  = 1'b1;
        cmd.kw      = KW_INS;
        cmd.st_we   = 1'b1;
        cmd.st_code = ST_DONE;
        state_next  = S_FIN;
      end
      S_VAL_RD: begin
        cmd.val_rd = 1'b1;
        state_next = S_VAL_OUT;
      end
      S_VAL_OUT: begin
        cmd.val_ld  = 1'b1;
        cmd.st_we   = 1'b1;
        cmd.st_code = ST_DONE;
        state_next  = S_FIN;
      end
      S_SPL_CHK: begin
        if (stat.full) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ST_FULL;
          state_next  = S_FIN;
        end else begin
          cmd.split_go = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_next   = S_SP_RD;
        end
      end
      S_SP_RD: begin
        cmd.key_rd = 1'b1;
        state_next = S_SP_CHK;
      end
      S_SP_CHK: begin
        if (stat.kq_empty) begin
          cmd.key_wr  = 1'b1;
          cmd.kw      = KW_SPE;
          cmd.idx_inc = !stat.idx_last;
          state_next  = sp_step;
        end else begin
          cmd.mix_start = 1'b1;
          cmd.mix_src   = 1'b1;
          state_next    = S_SP_HASH;
        end
      end
      S_SP_HASH: begin
        if (stat.mix_done) begin
          if (stat.split_bit) begin
            state_next = S_SP_VRD;
          end else begin
            cmd.key_wr  = 1'b1;
            cmd.kw      = KW_SPE;
            cmd.idx_inc = !stat.idx_last;
            state_next  = sp_step;
          end
        end
      end
      S_SP_VRD: begin
        cmd.val_rd = 1'b1;
        state_next = S_SP_VWR;
      end
      S_SP_VWR: begin
        cmd.key_wr  = 1'b1;
        cmd.kw      = KW_SPC;
        cmd.idx_inc = !stat.idx_last;
        state_next  = sp_step;
      end
      S_SP_LDN: begin
        cmd.ldn_wr = 1'b1;
        state_next = S_SP_LDO;
      end
      S_SP_LDO: begin
        cmd.ldo_wr = 1'b1;
        if (stat.dbl) begin
          cmd.j_init = 1'b1;
          state_next = S_DB_RD;
        end else begin
          cmd.hj_clr = 1'b1;
          state_next = S_HF_WR;
        end
      end
      S_DB_RD: begin
        cmd.dir_rd   = 1'b1;
        cmd.dir_asel = 1'b1;
        state_next   = S_DB_W0;
      end
      S_DB_W0: begin
        cmd.dbl_w0 = 1'b1;
        state_next = S_DB_W1;
      end
      S_DB_W1: begin
        cmd.dbl_w1 = 1'b1;
        if (stat.j_zero) begin
          cmd.gd_inc = 1'b1;
          state_next = S_LOOK;
        end else begin
          cmd.j_dec  = 1'b1;
          state_next = S_DB_RD;
        end
      end
      S_HF_WR: begin
        cmd.hf_wr = 1'b1;
        if (stat.hj_last) begin
          state_next = S_LOOK;
        end else begin
          cmd.hj_inc = 1'b1;
        end
      end
      S_FIN: begin
        // hold until the previous result has been taken
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/eht_chk.sv -----
module eht_chk import eht_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [63:0] found_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(status) && $stable(found_value))
    else $error("stalled result changed");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DONE) |-> found_value == '0)
    else $error("value returned without a hit");

  a_reset_busy: assert property (@(posedge clk)
    $past(rst) |-> in_stall && !out_valid)
    else $error("block not busy after reset");

  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in progress");

endmodule

bind extendible_hash_table_top eht_chk u_eht_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .found_value (found_value)
);
